// ===== hw/rtl/rau_pkg.sv =====
// shared constants and types for the rational arithmetic unit
package rau_pkg;

  localparam int OP_W  = 16;
  localparam int DW    = 2 * OP_W;
  localparam int NUM_W = DW + 1;
  localparam int DEN_W = DW;
  localparam int KW    = $clog2(DW + 1);

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_EQ  = 3'd4;
  localparam logic [2:0] KIND_NRM = 3'd5;

  typedef struct packed {
    logic          vld;
    logic          tag;
    logic [DW-1:0] rem;
    logic [DW-1:0] dq;
    logic [DW-1:0] dvs;
  } rau_lane_t;

endpackage

// ===== hw/rtl/rau_cell.sv =====
// one restoring division step of the divider chain
module rau_cell import rau_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  rau_lane_t lane_i,
  output rau_lane_t lane_o
);

  logic [DW:0] shifted;
  logic        ge;
  rau_lane_t   lane_d, lane_q;

  always_comb begin
    shifted = {lane_i.rem, lane_i.dq[DW-1]};
    ge      = shifted >= {1'b0, lane_i.dvs};
    lane_d  = lane_i;
    lane_d.rem = ge ? DW'(shifted - {1'b0, lane_i.dvs}) : shifted[DW-1:0];
    lane_d.dq  = {lane_i.dq[DW-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= '0;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign lane_o = lane_q;

endmodule

// ===== hw/rtl/rational_arithmetic_unit_core.sv =====
// top level of the rational arithmetic unit: products, gcd and divider chain
// One transaction at a time. Accepting an item, the unit forms its three products
// in turn on one shared multiplier, adds them, runs a binary gcd that
// takes one shift or subtract per cycle (at most two steps per bit of the two
// magnitudes), then sends numerator and denominator through a chain of 32
// division cells. A zero denominator skips the gcd and the chain and goes from
// the add step straight to the finish state; equal tests and unused kinds go
// there straight from idle. A finished result waits in the output register while
// the next item is accepted.
module rational_arithmetic_unit_core import rau_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [2:0]              kind_i,
  input  logic signed [OP_W-1:0]  a_num_i,
  input  logic signed [OP_W-1:0]  a_den_i,
  input  logic signed [OP_W-1:0]  b_num_i,
  input  logic signed [OP_W-1:0]  b_den_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic signed [NUM_W-1:0] res_num_o,
  output logic signed [DEN_W-1:0] res_den_o,
  output logic                    is_equal_o,
  output logic                    status_o
);

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_ADD, ST_GCD, ST_DIV, ST_FIN
  } state_e;

  state_e state_q;
  logic [2:0] kind_q;
  logic [OP_W-1:0] am_q, ad_q, bm_q, bd_q;
  logic an_q, adn_q, bn_q, bdn_q;
  logic [1:0] cnt_q;
  logic [DW-1:0] pa_q, pb_q, pd_q;
  logic sa_q, sb_q, sd_q;
  logic [DW-1:0] nm_q;
  logic nneg_q;
  logic [DW-1:0] u_q, v_q, g_q;
  logic [KW-1:0] k_q;
  logic [1:0] iss_q;
  logic [DW-1:0] qn_q;
  logic [NUM_W-1:0] rn_q;
  logic [DEN_W-1:0] rd_q;
  logic eq_q, st_q;
  logic out_valid_q;
  logic [NUM_W-1:0] res_num_q;
  logic [DEN_W-1:0] res_den_q;
  logic is_equal_q, status_q;

  logic [OP_W-1:0] mul_x, mul_y;
  logic [DW-1:0] prod;
  logic [DW-1:0] sum_mag;
  logic sum_neg;
  logic in_acc, fin_go;
  rau_lane_t lanes [DW+1];

  function automatic logic [OP_W-1:0] mag_of(input logic [OP_W-1:0] v);
    return v[OP_W-1] ? OP_W'(-v) : v;
  endfunction

  function automatic logic [NUM_W-1:0] enc(input logic neg, input logic [DW-1:0] m);
    return neg ? NUM_W'(-{1'b0, m}) : {1'b0, m};
  endfunction

  assign in_acc = in_valid_i && !in_stall_o;
  assign in_stall_o = state_q != ST_IDLE;
  assign fin_go = state_q == ST_FIN && (!out_valid_q || !out_stall_i);

  always_comb begin
    mul_x = am_q;
    mul_y = bd_q;
    unique case (cnt_q)
      2'd0: begin
        mul_x = am_q;
        mul_y = (kind_q == KIND_MUL) ? bm_q : (kind_q == KIND_NRM) ? OP_W'(1) : bd_q;
      end
      2'd1: begin
        mul_x = bm_q;
        mul_y = (kind_q == KIND_ADD || kind_q == KIND_SUB) ? ad_q : '0;
      end
      default: begin
        mul_x = ad_q;
        mul_y = (kind_q == KIND_DIV) ? bm_q : (kind_q == KIND_NRM) ? OP_W'(1) : bd_q;
      end
    endcase
    prod = DW'(mul_x) * DW'(mul_y);
  end

  always_comb begin
    if (sa_q == sb_q) begin
      sum_neg = sa_q;
      sum_mag = pa_q + pb_q;
    end else if (pa_q >= pb_q) begin
      sum_neg = sa_q;
      sum_mag = pa_q - pb_q;
    end else begin
      sum_neg = sb_q;
      sum_mag = pb_q - pa_q;
    end
  end

  always_comb begin
    lanes[0].vld = state_q == ST_DIV && iss_q != 2'd2;
    lanes[0].tag = iss_q[0];
    lanes[0].rem = '0;
    lanes[0].dq  = iss_q[0] ? pd_q : nm_q;
    lanes[0].dvs = g_q;
  end

  for (genvar i = 0; i < DW; i++) begin : g_chain
    rau_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .lane_i (lanes[i]),
      .lane_o (lanes[i+1])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      iss_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (fin_go) begin
        out_valid_q <= 1'b1;
        res_num_q   <= rn_q;
        res_den_q   <= rd_q;
        is_equal_q  <= eq_q;
        status_q    <= st_q;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            kind_q <= kind_i;
            am_q <= mag_of(a_num_i);
            ad_q <= mag_of(a_den_i);
            bm_q <= mag_of(b_num_i);
            bd_q <= mag_of(b_den_i);
            an_q <= a_num_i[OP_W-1];
            adn_q <= a_den_i[OP_W-1];
            bn_q <= b_num_i[OP_W-1];
            bdn_q <= b_den_i[OP_W-1];
            cnt_q <= '0;
            rn_q <= '0;
            rd_q <= '0;
            st_q <= 1'b0;
            eq_q <= kind_i == KIND_EQ && a_num_i == b_num_i && a_den_i == b_den_i;
            state_q <= (kind_i == KIND_EQ || kind_i > KIND_NRM) ? ST_FIN : ST_MUL;
          end
        end
        ST_MUL: begin
          unique case (cnt_q)
            2'd0: begin
              pa_q <= prod;
              sa_q <= (kind_q == KIND_MUL) ? (an_q ^ bn_q) :
                      (kind_q == KIND_NRM) ? an_q : (an_q ^ bdn_q);
            end
            2'd1: begin
              pb_q <= prod;
              sb_q <= bn_q ^ adn_q ^ (kind_q == KIND_SUB);
            end
            default: begin
              pd_q <= prod;
              sd_q <= (kind_q == KIND_DIV) ? (adn_q ^ bn_q) :
                      (kind_q == KIND_NRM) ? adn_q : (adn_q ^ bdn_q);
            end
          endcase
          cnt_q <= cnt_q + 2'd1;
          if (cnt_q == 2'd2) state_q <= ST_ADD;
        end
        ST_ADD: begin
          nm_q   <= sum_mag;
          nneg_q <= sum_neg;
          u_q    <= sum_mag;
          v_q    <= pd_q;
          k_q    <= '0;
          if (pd_q == '0) begin
            rn_q    <= enc(sum_neg, sum_mag);
            st_q    <= 1'b1;
            state_q <= ST_FIN;
          end else begin
            state_q <= ST_GCD;
          end
        end
        ST_GCD: begin
          priority if (u_q == '0) begin
            g_q     <= v_q << k_q;
            iss_q   <= '0;
            state_q <= ST_DIV;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + KW'(1);
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_q >= v_q) begin
            u_q <= u_q - v_q;
          end else begin
            v_q <= v_q - u_q;
          end
        end
        ST_DIV: begin
          if (iss_q != 2'd2) iss_q <= iss_q + 2'd1;
          if (lanes[DW].vld) begin
            if (!lanes[DW].tag) begin
              qn_q <= lanes[DW].dq;
            end else begin
              rn_q    <= enc(qn_q != '0 && (nneg_q != sd_q), qn_q);
              rd_q    <= lanes[DW].dq;
              state_q <= ST_FIN;
            end
          end
        end
        ST_FIN: begin
          if (fin_go) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_num_o   = res_num_q;
  assign res_den_o   = res_den_q;
  assign is_equal_o  = is_equal_q;
  assign status_o    = status_q;

  a_chain_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    lanes[DW].vld |-> state_q == ST_DIV) else $error("divider output outside divide phase");
  a_gcd_v_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_GCD |-> v_q != '0) else $error("gcd operand reached zero");
  a_status_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o |-> res_den_o == '0) else $error("zero denominator status mismatch");
  a_ok_den_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_go && !st_q && kind_q <= KIND_NRM && kind_q != KIND_EQ |-> rd_q != '0)
    else $error("reduced denominator is zero");

endmodule

// ===== verif/testbench.sv =====
// testbench for the rational arithmetic unit: directed table, random items, scoreboard
module testbench import rau_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [2:0] KIND_RSV6 = 3'd6;
  localparam logic [2:0] KIND_RSV7 = 3'd7;
  localparam int N_RANDOM  = 750;
  localparam int MAX_CYCLE = 800000;
  localparam int DRAIN_CYC = 300;

  typedef struct {
    logic [2:0]           kind;
    logic signed [OP_W-1:0] an, ad, bn, bd;
  } frac_item_t;

  typedef struct {
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
    logic                    eq;
    logic                    st;
  } frac_res_t;

  typedef struct {
    frac_item_t item;
    logic       typed;
    frac_res_t  res;
  } table_row_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [2:0]              kind_i;
  logic signed [OP_W-1:0]  a_num_i, a_den_i, b_num_i, b_den_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [NUM_W-1:0] res_num_o;
  logic signed [DEN_W-1:0] res_den_o;
  logic                    is_equal_o;
  logic                    status_o;

  frac_res_t  reduced_q[$];
  int         n_fail, n_sent, n_checked, n_holds, cyc;

  rational_arithmetic_unit_core DUT (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic longint gcd_mag(longint x, longint y);
    longint t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t reduce_fraction(frac_item_t it);
    frac_res_t r;
    longint an, ad, bn, bd, n, d, g, mn, md;
    an = it.an; ad = it.ad; bn = it.bn; bd = it.bd;
    r = '{num: '0, den: '0, eq: 1'b0, st: 1'b0};
    case (it.kind)
      KIND_ADD: begin n = an * bd + bn * ad; d = ad * bd; end
      KIND_SUB: begin n = an * bd - bn * ad; d = ad * bd; end
      KIND_MUL: begin n = an * bn; d = ad * bd; end
      KIND_DIV: begin n = an * bd; d = ad * bn; end
      KIND_NRM: begin n = an; d = ad; end
      KIND_EQ: begin
        r.eq = (it.an == it.bn) && (it.ad == it.bd);
        return r;
      end
      default: return r;
    endcase
    if (d == 0) begin
      r.num = n[NUM_W-1:0];
      r.st  = 1'b1;
      return r;
    end
    mn = (n < 0) ? -n : n;
    md = (d < 0) ? -d : d;
    g  = gcd_mag(mn, md);
    mn = mn / g;
    md = md / g;
    if (mn != 0 && ((n < 0) != (d < 0))) mn = -mn;
    r.num = mn[NUM_W-1:0];
    r.den = md[DEN_W-1:0];
    return r;
  endfunction

  function automatic logic signed [OP_W-1:0] pick_operand();
    logic signed [OP_W-1:0] v;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = OP_W'($signed($urandom_range(0, 24)) - 12);
      4, 5, 6:    v = OP_W'($urandom);
      7: begin
        case ($urandom_range(0, 4))
          0: v = 16'sh8000;
          1: v = 16'sh7fff;
          2: v = OP_W'(-1);
          3: v = OP_W'(1);
          default: v = '0;
        endcase
      end
      8: v = OP_W'(($urandom_range(0, 1) ? -1 : 1) * (1 << $urandom_range(0, 14)));
      default: v = '0;
    endcase
    return v;
  endfunction

  function automatic frac_item_t random_item();
    frac_item_t it;
    it.kind = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(6, 7)) :
              3'($urandom_range(0, 5));
    it.an = pick_operand();
    it.ad = pick_operand();
    if (it.kind == KIND_EQ && $urandom_range(0, 1)) begin
      it.bn = it.an;
      it.bd = it.ad;
    end else begin
      it.bn = pick_operand();
      it.bd = pick_operand();
    end
    return it;
  endfunction

  table_row_t dir_tab[] = '{
    '{'{KIND_EQ,  3, 4, 3, 4},       1'b1, '{0, 0, 1'b1, 1'b0}},
    '{'{KIND_EQ,  3, 4, 3, 5},       1'b1, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_EQ,  -32768, -32768, -32768, -32768}, 1'b1, '{0, 0, 1'b1, 1'b0}},
    '{'{KIND_NRM, 0, 5, 9, 9},       1'b1, '{0, 1, 1'b0, 1'b0}},
    '{'{KIND_NRM, 6, -4, 0, 0},      1'b1, '{-3, 2, 1'b0, 1'b0}},
    '{'{KIND_NRM, 7, 0, 1, 1},       1'b1, '{7, 0, 1'b0, 1'b1}},
    '{'{KIND_NRM, -32768, -32768, 0, 0}, 1'b1, '{1, 1, 1'b0, 1'b0}},
    '{'{KIND_MUL, 2, 0, 3, 5},       1'b1, '{6, 0, 1'b0, 1'b1}},
    '{'{KIND_DIV, 5, 3, 0, 7},       1'b1, '{35, 0, 1'b0, 1'b1}},
    '{'{KIND_SUB, 1, 2, 1, 2},       1'b1, '{0, 1, 1'b0, 1'b0}},
    '{'{KIND_ADD, 1, 2, 1, 3},       1'b1, '{5, 6, 1'b0, 1'b0}},
    '{'{KIND_RSV6, 5, 6, 7, 8},      1'b1, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_RSV7, -1, -1, -1, -1},  1'b1, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_ADD, 32767, 32767, 32767, 32767},     1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_ADD, -32768, -32768, -32768, -32768}, 1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_SUB, -32768, 1, 32767, 1},            1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_SUB, -32768, 32767, 32767, -32768},   1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_MUL, -32768, 1, -32768, 1},           1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_DIV, 1, -32768, -32768, 1},           1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_ADD, 3, 0, 4, 0},                     1'b0, '{0, 0, 1'b0, 1'b0}},
    '{'{KIND_DIV, 32767, -1, -32768, 32767},       1'b0, '{0, 0, 1'b0, 1'b0}}
  };

  initial begin
    frac_item_t it;
    frac_res_t  want;
    int         burst;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    kind_i      = '0;
    a_num_i     = '0;
    a_den_i     = '0;
    b_num_i     = '0;
    b_den_i     = '0;
    n_sent      = 0;
    burst       = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int i = 0; i < dir_tab.size() + N_RANDOM; i++) begin
      it = (i < dir_tab.size()) ? dir_tab[i].item : random_item();
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          in_valid_i <= 1'b0;
          repeat ($urandom_range(1, 30)) @(posedge clk_i);
        end
      end
      burst--;
      in_valid_i <= 1'b1;
      kind_i     <= it.kind;
      a_num_i    <= it.an;
      a_den_i    <= it.ad;
      b_num_i    <= it.bn;
      b_den_i    <= it.bd;
      do @(posedge clk_i); while (in_stall_o);
      want = (i < dir_tab.size() && dir_tab[i].typed) ? dir_tab[i].res :
             reduce_fraction(it);
      reduced_q.push_back(want);
      n_sent++;
    end
    in_valid_i  <= 1'b0;
    wait (reduced_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("%0d transactions sent (directed table and random), %0d results checked,",
             n_sent, n_checked);
    $display("receiver stall patterns varied with %0d long hold-offs", n_holds);
    if (n_fail == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    int hold;
    out_stall_i = 1'b0;
    hold        = 0;
    n_holds     = 0;
    forever begin
      @(posedge clk_i);
      if (hold == 0 && n_holds == 0 && n_sent == 200) begin
        hold = 800;
        n_holds++;
      end
      if (hold > 0) begin
        hold--;
        out_stall_i <= 1'b1;
      end else begin
        case ((cyc / 3000) % 3)
          0: out_stall_i <= 1'b0;
          1: out_stall_i <= ($urandom_range(0, 3) == 0);
          default: out_stall_i <= ($urandom_range(0, 9) < 6);
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    frac_res_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (reduced_q.size() == 0) begin
        $error("result with no transaction pending");
        n_fail++;
      end else begin
        want = reduced_q.pop_front();
        n_checked++;
        if (res_num_o !== want.num) begin
          $error("res_num expected %0d actual %0d", want.num, res_num_o);
          n_fail++;
        end
        if (res_den_o !== want.den) begin
          $error("res_den expected %0d actual %0d", want.den, res_den_o);
          n_fail++;
        end
        if (is_equal_o !== want.eq) begin
          $error("is_equal expected %0b actual %0b", want.eq, is_equal_o);
          n_fail++;
        end
        if (status_o !== want.st) begin
          $error("status expected %0b actual %0b", want.st, status_o);
          n_fail++;
        end
      end
    end
  end

  initial begin
    n_fail    = 0;
    n_checked = 0;
    cyc       = 0;
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc > MAX_CYCLE) begin
        $display("timeout after %0d cycles, %0d results outstanding", cyc, reduced_q.size());
        $display("testbench NOT OK");
        $finish;
      end
    end
  end

endmodule
